[rtl/core/array_list_insert_delete_core_macros.svh]
// -----------------------------------------------------------------------------
// Array list core assertion macros
// Shared concurrent assertion forms for the array list checkers.
// -----------------------------------------------------------------------------
`ifndef ARRAY_LIST_INSERT_DELETE_CORE_MACROS_SVH
`define ARRAY_LIST_INSERT_DELETE_CORE_MACROS_SVH

// Plain property under clock and active-low reset
`define ALID_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define ALID_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  `ALID_ASSERT(name, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication
`define ALID_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  `ALID_ASSERT(name, clk, rst_n, (ante) |=> (cons), msg)

`endif

[rtl/core/alid_pkg.sv]
// -----------------------------------------------------------------------------
// Array list package
// Sizes, operation and status codes, and the controller/datapath interface.
// -----------------------------------------------------------------------------
package alid_pkg;

  localparam int DEPTH   = 64;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int WORD_W  = 32;
  localparam int OP_W    = 3;
  localparam int STAT_W  = 2;
  localparam int LOC_W   = 7;
  localparam int WHERE_W = 6;
  localparam int ECNT_W  = 7;
  localparam int CMP_W   = (CNT_W > LOC_W) ? CNT_W : LOC_W;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND     = 3'd0,
    OP_INS_BEFORE = 3'd1,
    OP_INS_AFTER  = 3'd2,
    OP_DELETE     = 3'd3,
    OP_READ       = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_NOKEY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SR_RD,
    S_SR_CMP,
    S_UP_RD,
    S_UP_WR,
    S_DN_RD,
    S_DN_WR,
    S_RD_ISSUE,
    S_RD_WAIT
  } state_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC,
    PTR_COUNT,
    PTR_LOC
  } ptr_op_e;

  typedef enum logic [1:0] {
    SLOT_HOLD,
    SLOT_COUNT,
    SLOT_LOC,
    SLOT_HIT
  } slot_op_e;

  typedef enum logic [1:0] {
    RA_PTR,
    RA_PTR_INC,
    RA_PTR_DEC
  } raddr_sel_e;

  typedef enum logic {
    WD_NEW,
    WD_MEM
  } wdata_sel_e;

  typedef struct packed {
    logic       load;
    ptr_op_e    ptr_op;
    slot_op_e   slot_op;
    logic       rd_en;
    raddr_sel_e ra_sel;
    logic       wr_en;
    wdata_sel_e wd_sel;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       res_en;
    status_e    res_status;
    logic       res_read;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic empty;
    logic full;
    logic loc_bad;
    logic key_hit;
    logic ptr_last;
    logic at_slot;
  } stat_t;

endpackage

[rtl/core/alid_ctrl.sv]
// -----------------------------------------------------------------------------
// Array list controller
// Sequences search, shift, place and read steps and issues the result.
// -----------------------------------------------------------------------------
module alid_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  alid_pkg::stat_t stat_i,
  output alid_pkg::cmd_t  cmd_o,
  output logic            busy_o
);

  alid_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= alid_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.ptr_op      = alid_pkg::PTR_HOLD;
    cmd_o.slot_op     = alid_pkg::SLOT_HOLD;
    cmd_o.ra_sel      = alid_pkg::RA_PTR;
    cmd_o.wd_sel      = alid_pkg::WD_NEW;
    cmd_o.res_status  = alid_pkg::ST_OK;
    busy_o            = (state_q != alid_pkg::S_IDLE);

    unique case (state_q)
      alid_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = alid_pkg::S_DISPATCH;
        end
      end

      alid_pkg::S_DISPATCH: begin
        unique case (stat_i.op)
          alid_pkg::OP_APPEND: begin
            if (stat_i.full) begin
              cmd_o.res_en     = 1'b1;
              cmd_o.res_status = alid_pkg::ST_FULL;
              state_d          = alid_pkg::S_IDLE;
            end else begin
              cmd_o.slot_op = alid_pkg::SLOT_COUNT;
              cmd_o.ptr_op  = alid_pkg::PTR_COUNT;
              state_d       = alid_pkg::S_UP_RD;
            end
          end
          alid_pkg::OP_INS_BEFORE, alid_pkg::OP_INS_AFTER: begin
            if (stat_i.empty) begin
              cmd_o.res_en     = 1'b1;
              cmd_o.res_status = alid_pkg::ST_NOKEY;
              state_d          = alid_pkg::S_IDLE;
            end else begin
              cmd_o.ptr_op = alid_pkg::PTR_ZERO;
              state_d      = alid_pkg::S_SR_RD;
            end
          end
          alid_pkg::OP_DELETE, alid_pkg::OP_READ: begin
            if (stat_i.loc_bad) begin
              cmd_o.res_en     = 1'b1;
              cmd_o.res_status = alid_pkg::ST_BADPOS;
              state_d          = alid_pkg::S_IDLE;
            end else begin
              cmd_o.slot_op = alid_pkg::SLOT_LOC;
              cmd_o.ptr_op  = alid_pkg::PTR_LOC;
              state_d       = (stat_i.op == alid_pkg::OP_READ) ? alid_pkg::S_RD_ISSUE
                                                               : alid_pkg::S_DN_RD;
            end
          end
          default: begin
            cmd_o.res_en     = 1'b1;
            cmd_o.res_status = alid_pkg::ST_BADPOS;
            state_d          = alid_pkg::S_IDLE;
          end
        endcase
      end

      // Key search: fetch one entry, then compare it
      alid_pkg::S_SR_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.ra_sel = alid_pkg::RA_PTR;
        state_d      = alid_pkg::S_SR_CMP;
      end

      alid_pkg::S_SR_CMP: begin
        if (stat_i.key_hit) begin
          if (stat_i.full) begin
            cmd_o.res_en     = 1'b1;
            cmd_o.res_status = alid_pkg::ST_FULL;
            state_d          = alid_pkg::S_IDLE;
          end else begin
            cmd_o.slot_op = alid_pkg::SLOT_HIT;
            cmd_o.ptr_op  = alid_pkg::PTR_COUNT;
            state_d       = alid_pkg::S_UP_RD;
          end
        end else if (stat_i.ptr_last) begin
          cmd_o.res_en     = 1'b1;
          cmd_o.res_status = alid_pkg::ST_NOKEY;
          state_d          = alid_pkg::S_IDLE;
        end else begin
          cmd_o.ptr_op = alid_pkg::PTR_INC;
          state_d      = alid_pkg::S_SR_RD;
        end
      end

      // Open a gap from the top down to the slot, then place the word
      alid_pkg::S_UP_RD: begin
        if (stat_i.at_slot) begin
          cmd_o.wr_en      = 1'b1;
          cmd_o.wd_sel     = alid_pkg::WD_NEW;
          cmd_o.cnt_inc    = 1'b1;
          cmd_o.res_en     = 1'b1;
          cmd_o.res_status = alid_pkg::ST_OK;
          state_d          = alid_pkg::S_IDLE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.ra_sel = alid_pkg::RA_PTR_DEC;
          state_d      = alid_pkg::S_UP_WR;
        end
      end

      alid_pkg::S_UP_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wd_sel = alid_pkg::WD_MEM;
        cmd_o.ptr_op = alid_pkg::PTR_DEC;
        state_d      = alid_pkg::S_UP_RD;
      end

      // Close the gap from the slot up to the end
      alid_pkg::S_DN_RD: begin
        if (stat_i.ptr_last) begin
          cmd_o.cnt_dec    = 1'b1;
          cmd_o.res_en     = 1'b1;
          cmd_o.res_status = alid_pkg::ST_OK;
          state_d          = alid_pkg::S_IDLE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.ra_sel = alid_pkg::RA_PTR_INC;
          state_d      = alid_pkg::S_DN_WR;
        end
      end

      alid_pkg::S_DN_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wd_sel = alid_pkg::WD_MEM;
        cmd_o.ptr_op = alid_pkg::PTR_INC;
        state_d      = alid_pkg::S_DN_RD;
      end

      // Read one entry and return it
      alid_pkg::S_RD_ISSUE: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.ra_sel = alid_pkg::RA_PTR;
        state_d      = alid_pkg::S_RD_WAIT;
      end

      alid_pkg::S_RD_WAIT: begin
        cmd_o.res_en     = 1'b1;
        cmd_o.res_status = alid_pkg::ST_OK;
        cmd_o.res_read   = 1'b1;
        state_d          = alid_pkg::S_IDLE;
      end

      default: begin
        state_d = alid_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/alid_dp.sv]
// -----------------------------------------------------------------------------
// Array list datapath
// List memory, entry count, walk pointer, slot register and result word.
// -----------------------------------------------------------------------------
module alid_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  alid_pkg::cmd_t                         cmd_i,
  output alid_pkg::stat_t                        stat_o,
  input  logic             [alid_pkg::OP_W-1:0]   operation_i,
  input  logic             [alid_pkg::WORD_W-1:0] match_key_i,
  input  logic             [alid_pkg::WORD_W-1:0] new_element_i,
  input  logic             [alid_pkg::LOC_W-1:0]  location_i,
  output logic                                   res_valid_o,
  output alid_pkg::status_e                      res_status_o,
  output logic             [alid_pkg::IDX_W-1:0]  res_where_o,
  output logic             [alid_pkg::CNT_W-1:0]  count_o,
  output logic             [alid_pkg::WORD_W-1:0] res_value_o
);

  logic [alid_pkg::WORD_W-1:0] mem [alid_pkg::DEPTH];

  alid_pkg::op_e               op_q;
  logic [alid_pkg::WORD_W-1:0] key_q;
  logic [alid_pkg::WORD_W-1:0] word_q;
  logic [alid_pkg::LOC_W-1:0]  loc_q;
  logic [alid_pkg::CNT_W-1:0]  count_q, count_d;
  logic [alid_pkg::IDX_W-1:0]  ptr_q, ptr_d;
  logic [alid_pkg::IDX_W-1:0]  slot_q, slot_d;
  logic [alid_pkg::WORD_W-1:0] rdata_q;
  logic                        res_valid_q;
  alid_pkg::status_e           res_status_q;
  logic [alid_pkg::IDX_W-1:0]  res_where_q;
  logic [alid_pkg::WORD_W-1:0] res_value_q;

  logic [alid_pkg::IDX_W-1:0]  loc_idx;
  logic [alid_pkg::IDX_W-1:0]  count_idx;
  logic [alid_pkg::IDX_W-1:0]  hit_slot;
  logic [alid_pkg::IDX_W-1:0]  raddr;
  logic [alid_pkg::WORD_W-1:0] wdata;
  logic [alid_pkg::CNT_W-1:0]  ptr_next;

  assign loc_idx   = alid_pkg::IDX_W'(loc_q - alid_pkg::LOC_W'(1));
  assign count_idx = alid_pkg::IDX_W'(count_q);
  assign ptr_next  = alid_pkg::CNT_W'(ptr_q) + alid_pkg::CNT_W'(1);
  assign hit_slot  = alid_pkg::IDX_W'(alid_pkg::CNT_W'(ptr_q)
                   + alid_pkg::CNT_W'(op_q == alid_pkg::OP_INS_AFTER));

  // Status toward the controller
  always_comb begin
    stat_o.op       = op_q;
    stat_o.empty    = (count_q == '0);
    stat_o.full     = (count_q == alid_pkg::CNT_W'(alid_pkg::DEPTH));
    stat_o.loc_bad  = (loc_q == '0)
                   || (alid_pkg::CMP_W'(loc_q) > alid_pkg::CMP_W'(count_q));
    stat_o.key_hit  = (rdata_q == key_q);
    stat_o.ptr_last = (ptr_next >= count_q);
    stat_o.at_slot  = (ptr_q == slot_q);
  end

  // Latch the command word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= alid_pkg::op_e'(operation_i);
      key_q  <= match_key_i;
      word_q <= new_element_i;
      loc_q  <= location_i;
    end
  end

  // Pointer and slot update
  always_comb begin
    ptr_d = ptr_q;
    case (cmd_i.ptr_op)
      alid_pkg::PTR_ZERO:  ptr_d = '0;
      alid_pkg::PTR_INC:   ptr_d = alid_pkg::IDX_W'(ptr_next);
      alid_pkg::PTR_DEC:   ptr_d = ptr_q - alid_pkg::IDX_W'(1);
      alid_pkg::PTR_COUNT: ptr_d = count_idx;
      alid_pkg::PTR_LOC:   ptr_d = loc_idx;
      default:             ptr_d = ptr_q;
    endcase

    slot_d = slot_q;
    case (cmd_i.slot_op)
      alid_pkg::SLOT_COUNT: slot_d = count_idx;
      alid_pkg::SLOT_LOC:   slot_d = loc_idx;
      alid_pkg::SLOT_HIT:   slot_d = hit_slot;
      default:              slot_d = slot_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    slot_q <= slot_d;
  end

  // Entry count
  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + alid_pkg::CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - alid_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // List memory: one write at the pointer, one registered read
  always_comb begin
    case (cmd_i.ra_sel)
      alid_pkg::RA_PTR_INC: raddr = alid_pkg::IDX_W'(ptr_next);
      alid_pkg::RA_PTR_DEC: raddr = ptr_q - alid_pkg::IDX_W'(1);
      default:              raddr = ptr_q;
    endcase
    wdata = (cmd_i.wd_sel == alid_pkg::WD_MEM) ? rdata_q : word_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[ptr_q] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  // Result word: strobe for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.res_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_en) begin
      res_status_q <= cmd_i.res_status;
      res_where_q  <= (cmd_i.res_status == alid_pkg::ST_OK) ? slot_q : '0;
      res_value_q  <= cmd_i.res_read ? rdata_q : '0;
    end
  end

  assign res_valid_o  = res_valid_q;
  assign res_status_o = res_status_q;
  assign res_where_o  = res_where_q;
  assign count_o      = count_q;
  assign res_value_o  = res_value_q;

endmodule

[rtl/core/array_list_insert_delete_core.sv]
// -----------------------------------------------------------------------------
// Array list insert/delete core
// Ordered list of 32-bit words edited by append, keyed insert, delete, read.
// -----------------------------------------------------------------------------
// One command word at a time: start is taken when busy is low, and exactly one
// result word follows on strobe_o for a single cycle; it cannot be held off,
// so capture it when it shows. The list lives in a single-port-write memory
// with a registered read, walked one entry at a time: a read step, then a
// compare or write step. Errors found at dispatch end there; append places the
// word at the end, read fetches one entry, delete moves each entry after the
// position down, insert scans up to and including the key, then moves entries
// up from the slot; a missing key ends the scan after every entry held, and a
// full list ends it at the key. entry_count_o shows the count after the
// operation while strobe_o is high; busy drops in the strobe cycle.
module array_list_insert_delete_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  input  logic        [alid_pkg::OP_W-1:0]     operation_i,
  input  logic signed [alid_pkg::WORD_W-1:0]   match_key_i,
  input  logic signed [alid_pkg::WORD_W-1:0]   new_element_i,
  input  logic        [alid_pkg::LOC_W-1:0]    location_i,
  output logic                                 busy,
  output logic                                 strobe_o,
  output logic        [alid_pkg::STAT_W-1:0]   status_o,
  output logic        [alid_pkg::WHERE_W-1:0]  where_index_o,
  output logic        [alid_pkg::ECNT_W-1:0]   entry_count_o,
  output logic signed [alid_pkg::WORD_W-1:0]   read_value_o
);

  alid_pkg::cmd_t              cmd;
  alid_pkg::stat_t             stat;
  alid_pkg::status_e           res_status;
  logic [alid_pkg::IDX_W-1:0]  res_where;
  logic [alid_pkg::CNT_W-1:0]  count;
  logic [alid_pkg::WORD_W-1:0] res_value;

  // Sequencer
  alid_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  // Storage and result path
  alid_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .operation_i   (operation_i),
    .match_key_i   (match_key_i),
    .new_element_i (new_element_i),
    .location_i    (location_i),
    .res_valid_o   (strobe_o),
    .res_status_o  (res_status),
    .res_where_o   (res_where),
    .count_o       (count),
    .res_value_o   (res_value)
  );

  assign status_o      = res_status;
  assign where_index_o = alid_pkg::WHERE_W'(res_where);
  assign entry_count_o = alid_pkg::ECNT_W'(count);
  assign read_value_o  = res_value;

endmodule

[rtl/core/alid_assert.sv]
// -----------------------------------------------------------------------------
// Array list port checker
// Port-level properties of the array list core, bound to the top level.
// -----------------------------------------------------------------------------
`include "array_list_insert_delete_core_macros.svh"

module alid_assert (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 strobe_o,
  input logic        [alid_pkg::STAT_W-1:0]   status_o,
  input logic        [alid_pkg::WHERE_W-1:0]  where_index_o,
  input logic        [alid_pkg::ECNT_W-1:0]   entry_count_o,
  input logic signed [alid_pkg::WORD_W-1:0]   read_value_o
);

  // An accepted word keeps the core busy in the next cycle
  `ALID_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "accept did not raise busy")

  // A result word lasts one cycle
  `ALID_ASSERT_NXT(a_strobe_single, clk_i, rst_ni, strobe_o, !strobe_o, "result strobe held over")

  // Failed operations report no index and no data
  `ALID_ASSERT_IMP(a_err_zero, clk_i, rst_ni, strobe_o && (status_o != alid_pkg::ST_OK), (where_index_o == '0) && (read_value_o == '0), "error result carries data")

  // Failed operations leave the count alone
  `ALID_ASSERT_IMP(a_err_count, clk_i, rst_ni, strobe_o && (status_o != alid_pkg::ST_OK), entry_count_o == $past(entry_count_o), "error result changed count")

endmodule

bind array_list_insert_delete_core alid_assert u_alid_assert (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .strobe_o      (strobe_o),
  .status_o      (status_o),
  .where_index_o (where_index_o),
  .entry_count_o (entry_count_o),
  .read_value_o  (read_value_o)
);

[test/tb.sv]
// ----------------------------------------------------------------------------
// Array list insert/delete core testbench
// Drives command words through the start/busy handshake and predicts each
// result word from a shadow copy of the list. Every strobed result is checked
// field by field against the oldest prediction. A short directed sequence runs
// first, then random traffic that alternately fills the list and empties it.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import alid_pkg::*;

  localparam int RANDOM_WORDS = 550;

  localparam logic [OP_W-1:0] OP_UNUSED_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI  = 3'd7;

  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [LOC_W-1:0]         LOC_MAX  = '1;

  typedef struct packed {
    status_e                   status;
    logic [WHERE_W-1:0]        where_at;
    logic [ECNT_W-1:0]         count;
    logic signed [WORD_W-1:0]  value;
  } list_result_t;

  // Shadow list and the queue of result words still owed by the core
  class list_scoreboard;
    logic signed [WORD_W-1:0] words [DEPTH];
    int unsigned              held;
    list_result_t             pending_q[$];
    int unsigned              errors;

    function new();
      held   = 0;
      errors = 0;
    endfunction

    // Apply one accepted command word to the shadow list and queue its result
    function void note_command(input logic [OP_W-1:0] op,
                               input logic signed [WORD_W-1:0] key,
                               input logic signed [WORD_W-1:0] elem,
                               input logic [LOC_W-1:0] loc);
      list_result_t res;
      int           hit;
      int           slot;
      res  = '{status: ST_BADPOS, where_at: '0, count: '0, value: '0};
      hit  = -1;
      slot = 0;
      case (op)
        OP_APPEND: begin
          if (held >= DEPTH) begin
            res.status = ST_FULL;
          end else begin
            words[held]  = elem;
            res.status   = ST_OK;
            res.where_at = WHERE_W'(held);
            held++;
          end
        end
        OP_INS_BEFORE, OP_INS_AFTER: begin
          // first match wins
          for (int k = 0; k < int'(held); k++)
            if (hit < 0 && words[k] == key) hit = k;
          if (hit < 0) begin
            res.status = ST_NOKEY;
          end else if (held >= DEPTH) begin
            res.status = ST_FULL;
          end else begin
            slot = (op == OP_INS_BEFORE) ? hit : hit + 1;
            for (int k = int'(held); k > slot; k--) words[k] = words[k-1];
            words[slot]  = elem;
            held++;
            res.status   = ST_OK;
            res.where_at = WHERE_W'(slot);
          end
        end
        OP_DELETE, OP_READ: begin
          if (loc == 0 || loc > held) begin
            res.status = ST_BADPOS;
          end else begin
            slot         = int'(loc) - 1;
            res.status   = ST_OK;
            res.where_at = WHERE_W'(slot);
            if (op == OP_READ) begin
              res.value = words[slot];
            end else begin
              // close the gap
              for (int k = slot; k + 1 < int'(held); k++) words[k] = words[k+1];
              held--;
            end
          end
        end
        default: res.status = ST_BADPOS;
      endcase
      res.count = ECNT_W'(held);
      pending_q.push_back(res);
    endfunction

    function void compare_field(input string name, input logic [WORD_W-1:0] want,
                                input logic [WORD_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    // Check one strobed result word against the oldest prediction
    function void check_result(input logic [STAT_W-1:0] status,
                               input logic [WHERE_W-1:0] where_at,
                               input logic [ECNT_W-1:0] count,
                               input logic signed [WORD_W-1:0] value);
      list_result_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, actual status %0d",
                 $time, status);
      end else begin
        want = pending_q.pop_front();
        compare_field("status", want.status, status);
        compare_field("where_index", want.where_at, where_at);
        compare_field("entry_count", want.count, count);
        compare_field("read_value", want.value, value);
      end
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic [OP_W-1:0]            operation_i;
  logic signed [WORD_W-1:0]   match_key_i;
  logic signed [WORD_W-1:0]   new_element_i;
  logic [LOC_W-1:0]           location_i;
  logic                       busy;
  logic                       strobe_o;
  logic [STAT_W-1:0]          status_o;
  logic [WHERE_W-1:0]         where_index_o;
  logic [ECNT_W-1:0]          entry_count_o;
  logic signed [WORD_W-1:0]   read_value_o;

  list_scoreboard sb = new();

  array_list_insert_delete_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .operation_i   (operation_i),
    .match_key_i   (match_key_i),
    .new_element_i (new_element_i),
    .location_i    (location_i),
    .busy          (busy),
    .strobe_o      (strobe_o),
    .status_o      (status_o),
    .where_index_o (where_index_o),
    .entry_count_o (entry_count_o),
    .read_value_o  (read_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Capture every strobed result word; it cannot be held off
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o)
      sb.check_result(status_o, where_index_o, entry_count_o, read_value_o);
  end

  // Present one command word and hold it until the core takes it
  task automatic issue(input logic [OP_W-1:0] op, input logic signed [WORD_W-1:0] key,
                       input logic signed [WORD_W-1:0] elem, input logic [LOC_W-1:0] loc);
    operation_i   <= op;
    match_key_i   <= key;
    new_element_i <= elem;
    location_i    <= loc;
    start         <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_command(op, key, elem, loc);
  endtask

  // Drop start now and then for a random idle stretch
  task automatic idle_between(input bit quiet);
    if (!quiet && $urandom_range(99) < 26) begin
      start <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk_i);
    end
  endtask

  // Hold off until every owed result word has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  // Build one random command word, biased toward filling or emptying the list
  task automatic random_command(input bit grow);
    logic [OP_W-1:0]          op;
    logic signed [WORD_W-1:0] key;
    logic signed [WORD_W-1:0] elem;
    logic [LOC_W-1:0]         loc;
    int unsigned              pick;
    int unsigned              held;
    held = sb.held;
    pick = $urandom_range(99);
    if (grow)
      op = pick < 35 ? OP_APPEND : pick < 50 ? OP_INS_BEFORE : pick < 65 ? OP_INS_AFTER :
           pick < 75 ? OP_DELETE : pick < 95 ? OP_READ :
           OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
    else
      op = pick < 5 ? OP_APPEND : pick < 10 ? OP_INS_BEFORE : pick < 15 ? OP_INS_AFTER :
           pick < 75 ? OP_DELETE : pick < 95 ? OP_READ :
           OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
    // keys mostly hit an entry already in the list
    if (held > 0 && $urandom_range(99) < 85)
      key = sb.words[$urandom_range(held - 1)];
    else
      key = $urandom;
    // small values repeat, so first-match search gets exercised
    if ($urandom_range(3) == 0) begin
      elem = $urandom_range(7);
      elem = elem - 4;
    end else begin
      elem = $urandom;
    end
    pick = $urandom_range(99);
    if (pick < 70 && held > 0)
      loc = LOC_W'($urandom_range(held, 1));
    else if (pick < 80)
      loc = '0;
    else if (pick < 90)
      loc = LOC_W'(held + 1);
    else
      loc = LOC_W'($urandom_range(LOC_MAX));
    issue(op, key, elem, loc);
  endtask

  initial begin
    bit          grow;
    int unsigned n;
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    operation_i   <= OP_APPEND;
    match_key_i   <= '0;
    new_element_i <= '0;
    location_i    <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list: bad positions and a missing key
    issue(OP_READ, '0, '0, '0);
    issue(OP_DELETE, '0, '0, 7'd1);
    issue(OP_INS_BEFORE, '0, 32'sd1, '0);
    // Extremes, then inserts at head, middle and tail, and a missing key
    issue(OP_APPEND, '0, WORD_MAX, '0);
    issue(OP_APPEND, '0, WORD_MIN, LOC_MAX);
    issue(OP_APPEND, WORD_MAX, '0, '0);
    issue(OP_APPEND, WORD_MIN, -32'sd1, '0);
    issue(OP_INS_BEFORE, WORD_MIN, 32'sd5, '0);
    issue(OP_INS_AFTER, -32'sd1, 32'sd5, '0);
    issue(OP_INS_AFTER, 32'sd5, 32'sd7, '0);
    issue(OP_INS_BEFORE, 32'sd12345, 32'sd9, '0);
    issue(OP_INS_AFTER, WORD_MAX, WORD_MIN, '0);
    issue(OP_INS_BEFORE, WORD_MAX, -32'sd1, '0);
    // Reads at the ends and past them
    issue(OP_READ, '0, '0, 7'd1);
    issue(OP_READ, '0, '0, LOC_W'(sb.held));
    issue(OP_READ, '0, '0, LOC_W'(sb.held + 1));
    issue(OP_READ, WORD_MIN, WORD_MAX, LOC_MAX);
    // Deletes at head and tail, position zero, far past the end
    issue(OP_DELETE, '0, '0, 7'd1);
    issue(OP_DELETE, '0, '0, LOC_W'(sb.held));
    issue(OP_DELETE, '0, '0, '0);
    issue(OP_DELETE, '0, '0, LOC_MAX);
    // Unused operation codes
    issue(OP_UNUSED_LO, -32'sd1, -32'sd1, LOC_MAX);
    issue(OP_UNUSED_MID, WORD_MIN, WORD_MAX, 7'd1);
    issue(OP_UNUSED_HI, WORD_MAX, WORD_MIN, '0);
    issue(OP_READ, '0, '0, 7'd2);
    drain();

    // Random traffic: fill toward full, linger, then empty out
    grow = 1'b1;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (sb.held >= DEPTH && $urandom_range(9) == 0)
        grow = 1'b0;
      else if (sb.held == 0)
        grow = 1'b1;
      random_command(grow);
      if ($urandom_range(49) == 0)
        drain();
      else
        idle_between(n >= 200 && n < 300);
    end

    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Watchdog well beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
